FILE: src/lrme_pkg.sv
// ----------------------------------------------------------------------------
// lrme_pkg
// Types and constants shared by the link range mode estimator.
// ----------------------------------------------------------------------------
package lrme_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    MODE_NEUTRAL = 2'd0,
    MODE_SHORT   = 2'd1,
    MODE_LONG    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_SENT = 2'd1,
    REQ_IDLE = 2'd2,
    REQ_RSVD = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_SHORT_CODE   = 3'd0,
    REG_LONG_CODE    = 3'd1,
    REG_LOW_THRESH   = 3'd2,
    REG_HIGH_THRESH  = 3'd3,
    REG_FAST_PACKETS = 3'd4,
    REG_MID_PACKETS  = 3'd5,
    REG_MONITOR_LIM  = 3'd6,
    REG_FAIL_LIM     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0] range_mode;
    logic       reconfigure;
    logic       reconfigure_long;
    logic [2:0] error_weight;
    logic [2:0] error_average;
  } out_res_t;

  typedef struct packed {
    logic [1:0] short_code;
    logic [1:0] long_code;
    logic [2:0] low_threshold;
    logic [2:0] high_threshold;
    logic [7:0] fast_phase_packets;
    logic [7:0] mid_phase_packets;
    logic [7:0] monitor_limit;
    logic [7:0] fail_limit;
  } cfg_t;

endpackage

FILE: src/link_range_mode_estimator.sv
// ----------------------------------------------------------------------------
// link_range_mode_estimator
// Link quality and range mode estimator for a control radio.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while not stalled. An accepted request
// sits in the input register and is evaluated there; when it advances, its
// result, if any, enters the output register, which drives out_valid_o.
// Non-final packet bytes only update the fold and produce no result. The
// input register holds one request while a result waits to be taken; the
// input stalls only when both are occupied. Write configuration only while
// no request is in flight.
module link_range_mode_estimator #(
  parameter int unsigned HISTORY_LEN = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lrme_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lrme_pkg::out_res_t             out_res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrme_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lrme_pkg::CfgDataW-1:0]  pwdata,
  output logic [lrme_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  lrme_pkg::cfg_t     cfg;
  lrme_pkg::in_req_t  in_q;
  lrme_pkg::out_res_t res, out_q;
  logic               in_valid_d, in_valid_q;
  logic               out_valid_d, out_valid_q;
  logic               has_result, advance, accept;

  lrme_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  lrme_core #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_core (
    .clk_i,
    .rst_ni,
    .step_en_i    (advance),
    .req_i        (in_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .res_o        (res)
  );

  assign advance    = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_req_i;
    end
    if (advance && has_result) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

FILE: src/lrme_cfg.sv
// ----------------------------------------------------------------------------
// lrme_cfg
// APB-style register file holding the estimator configuration.
// ----------------------------------------------------------------------------
module lrme_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrme_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lrme_pkg::CfgDataW-1:0]  pwdata,
  output logic [lrme_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output lrme_pkg::cfg_t                 cfg_o
);

  lrme_pkg::cfg_t   cfg_d, cfg_q;
  lrme_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lrme_pkg::reg_idx_e'(paddr[lrme_pkg::CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        lrme_pkg::REG_SHORT_CODE:   cfg_d.short_code         = pwdata[1:0];
        lrme_pkg::REG_LONG_CODE:    cfg_d.long_code          = pwdata[1:0];
        lrme_pkg::REG_LOW_THRESH:   cfg_d.low_threshold      = pwdata[2:0];
        lrme_pkg::REG_HIGH_THRESH:  cfg_d.high_threshold     = pwdata[2:0];
        lrme_pkg::REG_FAST_PACKETS: cfg_d.fast_phase_packets = pwdata[7:0];
        lrme_pkg::REG_MID_PACKETS:  cfg_d.mid_phase_packets  = pwdata[7:0];
        lrme_pkg::REG_MONITOR_LIM:  cfg_d.monitor_limit      = pwdata[7:0];
        lrme_pkg::REG_FAIL_LIM:     cfg_d.fail_limit         = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lrme_pkg::REG_SHORT_CODE:   prdata = {30'd0, cfg_q.short_code};
      lrme_pkg::REG_LONG_CODE:    prdata = {30'd0, cfg_q.long_code};
      lrme_pkg::REG_LOW_THRESH:   prdata = {29'd0, cfg_q.low_threshold};
      lrme_pkg::REG_HIGH_THRESH:  prdata = {29'd0, cfg_q.high_threshold};
      lrme_pkg::REG_FAST_PACKETS: prdata = {24'd0, cfg_q.fast_phase_packets};
      lrme_pkg::REG_MID_PACKETS:  prdata = {24'd0, cfg_q.mid_phase_packets};
      lrme_pkg::REG_MONITOR_LIM:  prdata = {24'd0, cfg_q.monitor_limit};
      lrme_pkg::REG_FAIL_LIM:     prdata = {24'd0, cfg_q.fail_limit};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_code         <= 2'd1;
      cfg_q.long_code          <= 2'd2;
      cfg_q.low_threshold      <= 3'd1;
      cfg_q.high_threshold     <= 3'd3;
      cfg_q.fast_phase_packets <= 8'd30;
      cfg_q.mid_phase_packets  <= 8'd200;
      cfg_q.monitor_limit      <= 8'd15;
      cfg_q.fail_limit         <= 8'd75;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/lrme_core.sv
// ----------------------------------------------------------------------------
// lrme_core
// Estimator state and the combinational update for one request.
// ----------------------------------------------------------------------------
module lrme_core #(
  parameter int unsigned HISTORY_LEN = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  lrme_pkg::in_req_t  req_i,
  input  lrme_pkg::cfg_t     cfg_i,
  output logic               has_result_o,
  output lrme_pkg::out_res_t res_o
);

  function automatic logic [2:0] ones6(input logic [5:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  logic [7:0]        fold_d, fold_q;
  logic [2:0]        smooth_d, smooth_q;
  logic [2:0]        weight_d, weight_q;
  logic [7:0]        pcnt_d, pcnt_q;
  logic [7:0]        silent_mid, silent_d, silent_q;
  lrme_pkg::mode_e   mode_d, mode_q;
  lrme_pkg::mode_e   prev_d, prev_q;
  lrme_pkg::mode_e   pkt_mode, cand;
  lrme_pkg::mode_e   hist_q [HISTORY_LEN];

  logic [5:0] err;
  logic [2:0] ew, avg;
  logic [1:0] mode_bits;
  logic [6:0] sum_fast, sum_mid, sum_slow;
  logic       all_short, all_neutral, any_long;
  logic       reconf, reconf_long, has_result;

  assign err[5:2]  = req_i.data_byte[7:4] ^ fold_q[7:4];
  assign err[1:0]  = req_i.data_byte[3:2] ^ fold_q[3:2] ^ req_i.data_byte[1:0];
  assign ew        = ones6(err);
  assign mode_bits = req_i.data_byte[1:0];

  assign sum_fast = 7'(smooth_q) * 7'd5  + 7'(ew) * 7'd3;
  assign sum_mid  = 7'(smooth_q) * 7'd11 + 7'(ew) * 7'd5;
  assign sum_slow = 7'(smooth_q) * 7'd13 + 7'(ew) * 7'd3;

  always_comb begin
    if (pcnt_q < cfg_i.fast_phase_packets) begin
      avg = sum_fast[5:3];
    end else if (pcnt_q < cfg_i.mid_phase_packets) begin
      avg = sum_mid[6:4];
    end else begin
      avg = sum_slow[6:4];
    end
  end

  always_comb begin
    all_short   = 1'b1;
    all_neutral = 1'b1;
    any_long    = 1'b0;
    for (int i = 0; i < HISTORY_LEN; i++) begin
      if (hist_q[i] != lrme_pkg::MODE_SHORT)   all_short   = 1'b0;
      if (hist_q[i] != lrme_pkg::MODE_NEUTRAL) all_neutral = 1'b0;
      if (hist_q[i] == lrme_pkg::MODE_LONG)    any_long    = 1'b1;
    end
  end

  always_comb begin
    if (avg <= cfg_i.low_threshold) begin
      cand = (mode_bits == cfg_i.short_code && ew <= cfg_i.low_threshold) ?
             lrme_pkg::MODE_SHORT : lrme_pkg::MODE_NEUTRAL;
    end else if (avg > cfg_i.high_threshold) begin
      cand = lrme_pkg::MODE_LONG;
    end else begin
      cand = (mode_bits == cfg_i.long_code) ? lrme_pkg::MODE_LONG : lrme_pkg::MODE_NEUTRAL;
    end
  end

  always_comb begin
    case (cand)
      lrme_pkg::MODE_SHORT:
        pkt_mode = (all_short || all_neutral) ? lrme_pkg::MODE_SHORT : lrme_pkg::MODE_NEUTRAL;
      lrme_pkg::MODE_LONG:
        pkt_mode = any_long ? lrme_pkg::MODE_LONG : lrme_pkg::MODE_NEUTRAL;
      default:
        pkt_mode = (hist_q[0] == lrme_pkg::MODE_NEUTRAL && hist_q[1] == lrme_pkg::MODE_NEUTRAL) ?
                   lrme_pkg::MODE_LONG : lrme_pkg::MODE_NEUTRAL;
    endcase
  end

  always_comb begin
    fold_d      = fold_q;
    smooth_d    = smooth_q;
    weight_d    = weight_q;
    pcnt_d      = pcnt_q;
    mode_d      = mode_q;
    prev_d      = prev_q;
    silent_mid  = silent_q;
    reconf      = 1'b0;
    reconf_long = 1'b0;
    has_result  = 1'b1;
    case (lrme_pkg::req_e'(req_i.req_type))
      lrme_pkg::REQ_BYTE: begin
        if (!req_i.last_byte) begin
          fold_d     = fold_q ^ req_i.data_byte;
          has_result = 1'b0;
        end else begin
          fold_d     = 8'd0;
          weight_d   = ew;
          smooth_d   = avg;
          mode_d     = pkt_mode;
          pcnt_d     = (pcnt_q == 8'hFF) ? pcnt_q : pcnt_q + 8'd1;
          silent_mid = 8'd0;
        end
      end
      lrme_pkg::REQ_SENT: begin
        if (prev_q != mode_q && mode_q != lrme_pkg::MODE_NEUTRAL) begin
          reconf      = 1'b1;
          reconf_long = (mode_q != lrme_pkg::MODE_SHORT);
        end
        prev_d = mode_q;
      end
      default: ;
    endcase
    if (lrme_pkg::req_e'(req_i.req_type) != lrme_pkg::REQ_BYTE &&
        mode_q != lrme_pkg::MODE_LONG && silent_q > cfg_i.monitor_limit) begin
      mode_d = lrme_pkg::MODE_NEUTRAL;
      if (silent_q > cfg_i.fail_limit) begin
        mode_d      = lrme_pkg::MODE_LONG;
        reconf      = 1'b1;
        reconf_long = 1'b1;
        silent_mid  = 8'd0;
      end
    end
    silent_d = (silent_mid == 8'hFF) ? silent_mid : silent_mid + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q   <= 8'd0;
      smooth_q <= 3'd0;
      weight_q <= 3'd0;
      pcnt_q   <= 8'd0;
      silent_q <= 8'd0;
      mode_q   <= lrme_pkg::MODE_NEUTRAL;
      prev_q   <= lrme_pkg::MODE_NONE;
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_q[i] <= lrme_pkg::MODE_NEUTRAL;
      end
    end else if (step_en_i) begin
      fold_q <= fold_d;
      if (has_result) begin
        smooth_q  <= smooth_d;
        weight_q  <= weight_d;
        pcnt_q    <= pcnt_d;
        silent_q  <= silent_d;
        mode_q    <= mode_d;
        prev_q    <= prev_d;
        hist_q[0] <= mode_d;
        for (int i = 1; i < HISTORY_LEN; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
    end
  end

  assign has_result_o           = has_result;
  assign res_o.range_mode       = mode_d;
  assign res_o.reconfigure      = reconf;
  assign res_o.reconfigure_long = reconf && reconf_long;
  assign res_o.error_weight     = weight_d;
  assign res_o.error_average    = smooth_d;

endmodule

FILE: src/lrme_checker.sv
// ----------------------------------------------------------------------------
// lrme_checker
// Port-level checks on the estimator results, bound to the top level.
// ----------------------------------------------------------------------------
module lrme_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lrme_pkg::out_res_t out_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result dropped or changed");

  a_long_needs_reconf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.reconfigure_long |-> out_res_o.reconfigure)
    else $error("long flag without reconfigure request");

  a_long_flag_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.reconfigure_long |->
      out_res_o.range_mode == lrme_pkg::MODE_LONG)
    else $error("long reconfigure while mode is not long");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.range_mode != lrme_pkg::MODE_NONE)
    else $error("result reports no mode");

  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.error_weight != 3'd7 && out_res_o.error_average != 3'd7)
    else $error("error weight or average out of range");

endmodule

bind link_range_mode_estimator lrme_checker u_lrme_checker (.*);
